// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with async reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, off while rst_n is low.
`define DEQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same check, using the clk and rst_n signals of the enclosing scope.
`define DEQ_ASSERT_LOCAL(name, prop, msg) \
    `DEQ_ASSERT(name, clk, rst_n, prop, msg)

`endif

// ===== hdl/deq_pkg.sv =====
// ---------------------------------------------------------------------------
// deq_pkg
// Widths, codes and shared types of the double-ended queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEQ_DEPTH = 512;
    localparam int WORD_W    = 32;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 10;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [REQ_W-1:0]         req_t;
    typedef logic [STAT_W-1:0]        stat_t;
    typedef logic [OCC_W-1:0]         occ_t;

    localparam req_t REQ_PUSH_BACK  = 2'd0;
    localparam req_t REQ_PUSH_FRONT = 2'd1;
    localparam req_t REQ_POP_BACK   = 2'd2;
    localparam req_t REQ_POP_FRONT  = 2'd3;

    localparam stat_t STAT_OK    = 2'd0;
    localparam stat_t STAT_EMPTY = 2'd1;
    localparam stat_t STAT_FULL  = 2'd2;

    // Controller to datapath command
    typedef struct packed {
        logic exec;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/deq_req_if.sv =====
// ---------------------------------------------------------------------------
// deq_req_if
// Request channel: valid/ready handshake with request type and push word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
    import deq_pkg::*;

    logic  valid;
    logic  ready;
    req_t  req_type;
    word_t push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/deq_rsp_if.sv =====
// ---------------------------------------------------------------------------
// deq_rsp_if
// Response channel: valid/ready handshake with popped word, status, occupancy.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface deq_rsp_if;
    import deq_pkg::*;

    logic  valid;
    logic  ready;
    word_t pop_value;
    stat_t status;
    occ_t  occupancy;

    modport source (output valid, output pop_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/deq_ctrl.sv =====
// ---------------------------------------------------------------------------
// deq_ctrl
// Two-state controller: take one request, then hold its response until taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output deq_pkg::dp_cmd_t     cmd
);
    import deq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic state_reg;
    logic state_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_RESP);
    assign cmd.exec  = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.exec)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/deq_datapath.sv =====
// ---------------------------------------------------------------------------
// deq_datapath
// Ring buffer with front/back pointers, word count and registered results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire deq_pkg::dp_cmd_t cmd,
    input  wire deq_pkg::req_t    req_type,
    input  wire deq_pkg::word_t   push_value,
    output deq_pkg::word_t        pop_value,
    output deq_pkg::stat_t        status,
    output deq_pkg::occ_t         occupancy
);
    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    word_t mem [DEPTH];

    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;
    stat_t            status_reg, status_next;
    logic             pop_ok_reg, pop_ok_next;
    word_t            rd_data_reg;

    logic [PTR_W-1:0] front_inc, front_dec, back_inc, back_dec;
    logic [PTR_W-1:0] addr;
    logic             wr_en;
    logic             rd_en;
    logic             is_full;
    logic             count_zero;

    // Pointers wrap in both directions, also for DEPTH not a power of two
    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + PTR_W'(1);
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - PTR_W'(1);
    assign back_inc  = (back_reg == PTR_LAST) ? '0 : back_reg + PTR_W'(1);
    assign back_dec  = (back_reg == '0) ? PTR_LAST : back_reg - PTR_W'(1);

    assign is_full    = (count_reg == CNT_FULL);
    assign count_zero = (count_reg == '0);

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        addr        = back_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        if (cmd.exec)
        begin
            status_next = STAT_OK;
            pop_ok_next = 1'b0;
            case (req_type)
                REQ_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        addr       = back_reg;
                        back_next  = back_inc;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        addr       = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP_BACK:
                begin
                    if (count_zero)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        pop_ok_next = 1'b1;
                        addr        = back_dec;
                        back_next   = back_dec;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (count_zero)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        pop_ok_next = 1'b1;
                        addr        = front_reg;
                        front_next  = front_inc;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            status_reg <= STAT_OK;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    // Zero the word for pushes and errors
    assign pop_value = pop_ok_reg ? rd_data_reg : '0;
    assign status    = status_reg;
    assign occupancy = OCC_W'(count_reg);

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words held in a ring buffer of DEPTH words.
// ---------------------------------------------------------------------------
// Usage:
//   req channel carries req_type (push back, push front, pop back, pop front)
//   and push_value. rsp channel returns one word per request: pop_value
//   (zero for pushes and errors), status (ok, pop from empty, push into
//   full) and occupancy after the request.
//   A request is taken when the block is idle. The memory access and the
//   pointer update happen in the accept cycle; the response is valid on the
//   next cycle. The block holds one request at a time: the controller
//   takes no new request until the pending response has been taken.
//   If the receiver stalls, the response holds and req.ready stays low
//   until the response is taken.
//   Reset empties the deque (pointers and count cleared) at once; the
//   memory contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);
    import deq_pkg::*;

    dp_cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req.req_type),
        .push_value (req.push_value),
        .pop_value  (rsp.pop_value),
        .status     (rsp.status),
        .occupancy  (rsp.occupancy)
    );

endmodule

`default_nettype wire

// ===== hdl/deq_checker.sv =====
// ---------------------------------------------------------------------------
// deq_checker
// Port-level checks of the deque's request/response sequencing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module deq_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire deq_pkg::word_t pop_value,
    input wire deq_pkg::stat_t status
);
    import deq_pkg::*;

    // Every accepted request gets its response on the next cycle
    `DEQ_ASSERT_LOCAL(a_rsp_after_req, req_valid && req_ready |=> rsp_valid, "no response")

    // No new request while a response is pending
    `DEQ_ASSERT_LOCAL(a_one_in_flight, rsp_valid |-> !req_ready, "request taken while busy")

    // Errors never carry a word
    `DEQ_ASSERT_LOCAL(a_err_zero, rsp_valid && status != STAT_OK |-> pop_value == '0, "err word")

    // Stalled response holds its payload
    `DEQ_ASSERT_LOCAL(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_value), "drop")

endmodule

bind double_ended_queue deq_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .pop_value (rsp.pop_value),
    .status    (rsp.status)
);

`default_nettype wire
